// ===== rtl/i2c_register_transfer_sequencer_core_assert.svh =====
// Assertion macros for the sequencer RTL.
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2crts_pkg.sv =====
package i2crts_pkg;

    localparam int MODE_W  = 3;
    localparam int IDX_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int SADDR_W = 7;

    // Item operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_ADDR = 3'd0,
        MODE_LOAD_DATA = 3'd1,
        MODE_START     = 3'd2,
        MODE_READY     = 3'd3,
        MODE_NACK      = 3'd4,
        MODE_READ_BACK = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_BUSY   = 2'd1,
        ST_FAILED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_ADDR    = 3'd0,
        PH_WRITE   = 3'd1,
        PH_RESTART = 3'd2,
        PH_READ    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // Where the transmit byte of a result comes from
    typedef enum logic [1:0] {
        TXS_NONE = 2'd0,
        TXS_ADDR = 2'd1,
        TXS_DATA = 2'd2
    } t_txsrc;

    typedef struct packed {
        t_txsrc               tx_src;
        logic                 send_start;
        logic [SADDR_W-1:0]   start_address;
        logic                 receive_mode;
        logic                 send_stop;
        logic                 stop_after_start;
        logic                 finished;
        t_status              status;
        logic                 rb_valid;
    } t_result;

endpackage

// ===== rtl/i2crts_ram.sv =====
module i2crts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/i2c_register_transfer_sequencer_core.sv =====
// The result of an accepted item appears on the output port in the next cycle.
// Throughput: one item per cycle while results are taken; the input stalls while
// a result waits, and the buffer memories take one access per item.
// Buffer bytes come out of the memories' registered read ports with the result.
// Reset (synchronous, active low): status idle, phase done, position and held
// counts zero, events disabled; buffer contents stay undefined until loaded.
`include "i2c_register_transfer_sequencer_core_assert.svh"

module i2c_register_transfer_sequencer_core #(
    parameter int ADDR_DEPTH = 4,
    parameter int DATA_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [4:0] i_index,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_slave_address,
    input  logic [2:0] i_addr_count,
    input  logic [5:0] i_data_count,
    input  logic       i_is_read,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_send_start,
    output logic [6:0] o_start_address,
    output logic       o_receive_mode,
    output logic       o_send_stop,
    output logic       o_stop_after_start,
    output logic       o_finished,
    output logic [1:0] o_status,
    output logic [7:0] o_read_byte
);

    localparam int MAXD = (ADDR_DEPTH > DATA_DEPTH) ? ADDR_DEPTH : DATA_DEPTH;
    localparam int PW   = $clog2(MAXD + 1);
    localparam int ACW  = $clog2(ADDR_DEPTH + 1);
    localparam int DCW  = $clog2(DATA_DEPTH + 1);
    localparam int AAW  = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
    localparam int DAW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int XW   = (DAW > i2crts_pkg::IDX_W) ? DAW : i2crts_pkg::IDX_W;

    // Control state
    i2crts_pkg::t_status r_status, n_status;
    i2crts_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]       r_position, n_position;
    logic                r_events_en, n_events_en;
    logic [ACW-1:0]      r_addr_cnt, n_addr_cnt;
    logic [DCW-1:0]      r_data_cnt, n_data_cnt;
    logic                r_is_read, n_is_read;
    logic [6:0]          r_slave, n_slave;

    // Output stage
    logic                r_out_valid;
    i2crts_pkg::t_result r_res, n_res;

    // Memory ports
    logic               w_a_we, w_a_re, w_d_we, w_d_re;
    logic [AAW-1:0]     w_a_waddr;
    logic [DAW-1:0]     w_d_waddr, w_d_raddr;
    logic [7:0]         w_a_rdata, w_d_rdata;

    logic               w_in_acc;
    logic [XW-1:0]      w_idx_x;
    logic [PW:0]        w_pos_inc;
    logic [ACW-1:0]     w_ac_sat;
    logic [DCW-1:0]     w_dc_sat;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_idx_x    = XW'(i_index);
    assign w_pos_inc  = (PW+1)'(r_position) + (PW+1)'(1);
    assign w_ac_sat   = (int'(i_addr_count) > ADDR_DEPTH) ? ACW'(ADDR_DEPTH)
                                                          : ACW'(i_addr_count);
    assign w_dc_sat   = (int'(i_data_count) > DATA_DEPTH) ? DCW'(DATA_DEPTH)
                                                          : DCW'(i_data_count);

    // Address byte buffer
    i2crts_ram #(.WIDTH(8), .DEPTH(ADDR_DEPTH)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (i_byte_value),
        .i_re    (w_a_re),
        .i_raddr (r_position[AAW-1:0]),
        .o_rdata (w_a_rdata)
    );

    // Data byte buffer
    i2crts_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (i_byte_value),
        .i_re    (w_d_re),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    // Next state, memory accesses and result for the accepted item
    always_comb begin
        n_status    = r_status;
        n_phase     = r_phase;
        n_position  = r_position;
        n_events_en = r_events_en;
        n_addr_cnt  = r_addr_cnt;
        n_data_cnt  = r_data_cnt;
        n_is_read   = r_is_read;
        n_slave     = r_slave;
        n_res       = '0;
        w_a_we      = 1'b0;
        w_a_re      = 1'b0;
        w_d_we      = 1'b0;
        w_d_re      = 1'b0;
        w_a_waddr   = w_idx_x[AAW-1:0];
        w_d_waddr   = w_idx_x[DAW-1:0];
        w_d_raddr   = w_idx_x[DAW-1:0];

        if (w_in_acc) begin
            case (i2crts_pkg::t_mode'(i_mode))
                i2crts_pkg::MODE_LOAD_ADDR: begin
                    w_a_we = (int'(i_index) < ADDR_DEPTH);
                end
                i2crts_pkg::MODE_LOAD_DATA: begin
                    w_d_we = (int'(i_index) < DATA_DEPTH);
                end
                i2crts_pkg::MODE_START: begin
                    if (r_status != i2crts_pkg::ST_BUSY) begin
                        n_addr_cnt  = w_ac_sat;
                        n_data_cnt  = w_dc_sat;
                        n_is_read   = i_is_read;
                        n_slave     = i_slave_address;
                        n_position  = '0;
                        n_status    = i2crts_pkg::ST_BUSY;
                        n_events_en = 1'b1;
                        if (w_ac_sat != '0) begin
                            n_phase = i2crts_pkg::PH_ADDR;
                        end else if (w_dc_sat != '0) begin
                            n_phase = i_is_read ? i2crts_pkg::PH_RESTART
                                                : i2crts_pkg::PH_WRITE;
                        end else begin
                            n_phase = i2crts_pkg::PH_DONE;
                        end
                        n_res.send_start    = 1'b1;
                        n_res.start_address = i_slave_address;
                    end
                end
                i2crts_pkg::MODE_READY: begin
                    if (r_events_en) begin
                        case (r_phase)
                            i2crts_pkg::PH_ADDR: begin
                                // send next register address byte
                                w_a_re       = 1'b1;
                                n_res.tx_src = i2crts_pkg::TXS_ADDR;
                                n_position   = PW'(w_pos_inc);
                                if (w_pos_inc >= (PW+1)'(r_addr_cnt)) begin
                                    if (r_data_cnt != '0) begin
                                        n_position = '0;
                                        n_phase = r_is_read ? i2crts_pkg::PH_RESTART
                                                            : i2crts_pkg::PH_WRITE;
                                    end else begin
                                        n_phase = i2crts_pkg::PH_DONE;
                                    end
                                end
                            end
                            i2crts_pkg::PH_WRITE: begin
                                // send next write byte
                                w_d_re       = 1'b1;
                                w_d_raddr    = r_position[DAW-1:0];
                                n_res.tx_src = i2crts_pkg::TXS_DATA;
                                n_position   = PW'(w_pos_inc);
                                if (w_pos_inc >= (PW+1)'(r_data_cnt)) begin
                                    n_phase = i2crts_pkg::PH_DONE;
                                end
                            end
                            i2crts_pkg::PH_RESTART: begin
                                // repeated start into receive mode
                                n_res.send_start       = 1'b1;
                                n_res.start_address    = r_slave;
                                n_res.receive_mode     = 1'b1;
                                n_res.stop_after_start = (r_data_cnt == DCW'(1));
                                n_phase                = i2crts_pkg::PH_READ;
                            end
                            i2crts_pkg::PH_READ: begin
                                // store received byte, stop before the last one
                                w_d_we     = 1'b1;
                                w_d_waddr  = r_position[DAW-1:0];
                                n_position = PW'(w_pos_inc);
                                if ((PW+2)'(w_pos_inc) + (PW+2)'(1)
                                        == (PW+2)'(r_data_cnt)) begin
                                    n_res.send_stop = 1'b1;
                                end else if (w_pos_inc >= (PW+1)'(r_data_cnt)) begin
                                    n_events_en    = 1'b0;
                                    n_status       = i2crts_pkg::ST_IDLE;
                                    n_res.finished = 1'b1;
                                end
                            end
                            default: begin
                                // completion: stop for writes, back to idle
                                n_events_en     = 1'b0;
                                n_status        = i2crts_pkg::ST_IDLE;
                                n_res.send_stop = !r_is_read;
                                n_res.finished  = 1'b1;
                            end
                        endcase
                    end
                end
                i2crts_pkg::MODE_NACK: begin
                    if (r_events_en) begin
                        n_events_en     = 1'b0;
                        n_status        = i2crts_pkg::ST_FAILED;
                        n_res.send_stop = 1'b1;
                        n_res.finished  = 1'b1;
                    end
                end
                i2crts_pkg::MODE_READ_BACK: begin
                    if (int'(i_index) < DATA_DEPTH) begin
                        w_d_re         = 1'b1;
                        n_res.rb_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_res.status = n_status;
        end
    end

    // Control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= i2crts_pkg::ST_IDLE;
            r_phase     <= i2crts_pkg::PH_DONE;
            r_position  <= '0;
            r_events_en <= 1'b0;
            r_addr_cnt  <= '0;
            r_data_cnt  <= '0;
            r_is_read   <= 1'b0;
            r_slave     <= '0;
        end else begin
            r_status    <= n_status;
            r_phase     <= n_phase;
            r_position  <= n_position;
            r_events_en <= n_events_en;
            r_addr_cnt  <= n_addr_cnt;
            r_data_cnt  <= n_data_cnt;
            r_is_read   <= n_is_read;
            r_slave     <= n_slave;
        end
    end

    // Output valid: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    // Result fields, buffer bytes straight from the memory read registers
    always_comb begin
        o_out_valid        = r_out_valid;
        o_tx_valid         = (r_res.tx_src != i2crts_pkg::TXS_NONE);
        case (r_res.tx_src)
            i2crts_pkg::TXS_ADDR: o_tx_byte = w_a_rdata;
            i2crts_pkg::TXS_DATA: o_tx_byte = w_d_rdata;
            default:              o_tx_byte = '0;
        endcase
        o_send_start       = r_res.send_start;
        o_start_address    = r_res.start_address;
        o_receive_mode     = r_res.receive_mode;
        o_send_stop        = r_res.send_stop;
        o_stop_after_start = r_res.stop_after_start;
        o_finished         = r_res.finished;
        o_status           = r_res.status;
        o_read_byte        = r_res.rb_valid ? w_d_rdata : '0;
    end

    `SEQ_ASSERT(a_events_match_busy,
        r_events_en == (r_status == i2crts_pkg::ST_BUSY),
        "events enable out of step with busy status")
    `SEQ_ASSERT(a_addr_pos_bound,
        (r_phase != i2crts_pkg::PH_ADDR) || (PW'(r_addr_cnt) > r_position),
        "address position beyond held count")
    `SEQ_ASSERT(a_finish_not_busy,
        !(o_out_valid && o_finished) || (o_status != i2crts_pkg::ST_BUSY),
        "finished result while still busy")
    `SEQ_ASSERT_NEXT(a_accept_gives_result, w_in_acc, o_out_valid,
        "accepted item gave no result")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_DEPTH   = 4;
    localparam int DATA_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_MAX   = 10;

    // Codes outside the operation set; the block must ignore them
    localparam logic [i2crts_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [i2crts_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [i2crts_pkg::MODE_W-1:0]  mode;
        logic [i2crts_pkg::IDX_W-1:0]   index;
        logic [i2crts_pkg::BYTE_W-1:0]  byte_value;
        logic [i2crts_pkg::SADDR_W-1:0] slave_address;
        logic [2:0]                     addr_count;
        logic [5:0]                     data_count;
        logic                           is_read;
    } t_seq_item;

    typedef struct packed {
        logic                           tx_valid;
        logic [i2crts_pkg::BYTE_W-1:0]  tx_byte;
        logic                           send_start;
        logic [i2crts_pkg::SADDR_W-1:0] start_address;
        logic                           receive_mode;
        logic                           send_stop;
        logic                           stop_after_start;
        logic                           finished;
        logic [1:0]                     status;
        logic [i2crts_pkg::BYTE_W-1:0]  read_byte;
    } t_seq_result;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [2:0] i_mode          = '0;
    logic [4:0] i_index         = '0;
    logic [7:0] i_byte_value    = '0;
    logic [6:0] i_slave_address = '0;
    logic [2:0] i_addr_count    = '0;
    logic [5:0] i_data_count    = '0;
    logic       i_is_read       = 1'b0;
    logic       i_out_ready     = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_send_start;
    logic [6:0] o_start_address;
    logic       o_receive_mode;
    logic       o_send_stop;
    logic       o_stop_after_start;
    logic       o_finished;
    logic [1:0] o_status;
    logic [7:0] o_read_byte;

    i2c_register_transfer_sequencer_core #(
        .ADDR_DEPTH(ADDR_DEPTH),
        .DATA_DEPTH(DATA_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_index           (i_index),
        .i_byte_value      (i_byte_value),
        .i_slave_address   (i_slave_address),
        .i_addr_count      (i_addr_count),
        .i_data_count      (i_data_count),
        .i_is_read         (i_is_read),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_tx_valid        (o_tx_valid),
        .o_tx_byte         (o_tx_byte),
        .o_send_start      (o_send_start),
        .o_start_address   (o_start_address),
        .o_receive_mode    (o_receive_mode),
        .o_send_stop       (o_send_stop),
        .o_stop_after_start(o_stop_after_start),
        .o_finished        (o_finished),
        .o_status          (o_status),
        .o_read_byte       (o_read_byte)
    );

    // Sequencer state as the testbench sees it
    i2crts_pkg::t_status seq_status    = i2crts_pkg::ST_IDLE;
    i2crts_pkg::t_phase  seq_phase     = i2crts_pkg::PH_DONE;
    int                  seq_pos       = 0;
    bit                  seq_events_on = 1'b0;
    int                  seq_ac        = 0;
    int                  seq_dc        = 0;
    bit                  seq_rd        = 1'b0;
    logic [6:0]          seq_sa        = '0;
    logic [7:0]          addr_mem [ADDR_DEPTH];
    logic [7:0]          data_mem [DATA_DEPTH];

    t_seq_result pending_results [$];

    int  items_sent        = 0;
    int  items_effective   = 0;
    int  results_checked   = 0;
    int  failures          = 0;
    int  writes_completed  = 0;
    int  reads_completed   = 0;
    int  transfers_aborted = 0;
    bit  tx_idle_on        = 1'b1;

    // Receiver stall control, owned by the checking process
    int  rx_stall_left = 0;
    int  rx_calm_left  = 0;
    bit  rx_idle_on    = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_seq_item seq_item(input logic [2:0] mode, input int idx,
                                           input int bval, input int sa, input int ac,
                                           input int dc, input bit rd);
        t_seq_item it;
        it.mode          = mode;
        it.index         = idx[4:0];
        it.byte_value    = bval[7:0];
        it.slave_address = sa[6:0];
        it.addr_count    = ac[2:0];
        it.data_count    = dc[5:0];
        it.is_read       = rd;
        return it;
    endfunction

    // Every field random, then the caller overrides what matters
    function automatic t_seq_item rand_item(input logic [2:0] mode);
        return seq_item(mode, $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, 127), $urandom_range(0, 7),
                        $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void close_transfer(inout t_seq_result r);
        seq_events_on = 1'b0;
        if (!seq_rd)
            r.send_stop = 1'b1;
        seq_status = i2crts_pkg::ST_IDLE;
        r.finished = 1'b1;
        if (seq_rd)
            reads_completed++;
        else
            writes_completed++;
    endfunction

    // Advance the sequencer by one item and return the result it produces
    function automatic t_seq_result sequence_step(input t_seq_item it, output bit effective);
        t_seq_result r;
        r = '0;
        effective = 1'b0;
        case (it.mode)
            i2crts_pkg::MODE_LOAD_ADDR: begin
                if (it.index < ADDR_DEPTH) begin
                    addr_mem[it.index] = it.byte_value;
                    effective = 1'b1;
                end
            end
            i2crts_pkg::MODE_LOAD_DATA: begin
                if (it.index < DATA_DEPTH) begin
                    data_mem[it.index] = it.byte_value;
                    effective = 1'b1;
                end
            end
            i2crts_pkg::MODE_START: begin
                if (seq_status != i2crts_pkg::ST_BUSY) begin
                    effective = 1'b1;
                    seq_ac = (it.addr_count > ADDR_DEPTH) ? ADDR_DEPTH : it.addr_count;
                    seq_dc = (it.data_count > DATA_DEPTH) ? DATA_DEPTH : it.data_count;
                    seq_rd = it.is_read;
                    seq_sa = it.slave_address;
                    seq_pos = 0;
                    seq_status = i2crts_pkg::ST_BUSY;
                    if (seq_ac != 0)
                        seq_phase = i2crts_pkg::PH_ADDR;
                    else if (seq_dc != 0)
                        seq_phase = seq_rd ? i2crts_pkg::PH_RESTART : i2crts_pkg::PH_WRITE;
                    else
                        seq_phase = i2crts_pkg::PH_DONE;
                    seq_events_on = 1'b1;
                    r.send_start = 1'b1;
                    r.start_address = it.slave_address;
                end
            end
            i2crts_pkg::MODE_READY: begin
                if (seq_events_on) begin
                    effective = 1'b1;
                    case (seq_phase)
                        i2crts_pkg::PH_ADDR: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = (seq_pos < ADDR_DEPTH) ? addr_mem[seq_pos] : '0;
                            seq_pos++;
                            if (seq_pos >= seq_ac) begin
                                if (seq_dc != 0) begin
                                    seq_pos = 0;
                                    seq_phase = seq_rd ? i2crts_pkg::PH_RESTART
                                                       : i2crts_pkg::PH_WRITE;
                                end else begin
                                    seq_phase = i2crts_pkg::PH_DONE;
                                end
                            end
                        end
                        i2crts_pkg::PH_WRITE: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = (seq_pos < DATA_DEPTH) ? data_mem[seq_pos] : '0;
                            seq_pos++;
                            if (seq_pos >= seq_dc)
                                seq_phase = i2crts_pkg::PH_DONE;
                        end
                        i2crts_pkg::PH_RESTART: begin
                            r.send_start = 1'b1;
                            r.start_address = seq_sa;
                            r.receive_mode = 1'b1;
                            if (seq_dc == 1)
                                r.stop_after_start = 1'b1;
                            seq_phase = i2crts_pkg::PH_READ;
                        end
                        i2crts_pkg::PH_READ: begin
                            if (seq_pos < DATA_DEPTH)
                                data_mem[seq_pos] = it.byte_value;
                            seq_pos++;
                            if (seq_pos + 1 == seq_dc)
                                r.send_stop = 1'b1;
                            else if (seq_pos >= seq_dc)
                                close_transfer(r);
                        end
                        default: close_transfer(r);
                    endcase
                end
            end
            i2crts_pkg::MODE_NACK: begin
                if (seq_events_on) begin
                    effective = 1'b1;
                    seq_events_on = 1'b0;
                    seq_status = i2crts_pkg::ST_FAILED;
                    r.send_stop = 1'b1;
                    r.finished = 1'b1;
                    transfers_aborted++;
                end
            end
            i2crts_pkg::MODE_READ_BACK: begin
                effective = 1'b1;
                r.read_byte = (it.index < DATA_DEPTH) ? data_mem[it.index] : '0;
            end
            default: ;
        endcase
        r.status = seq_status;
        return r;
    endfunction

    function automatic string show_result(input t_seq_result r);
        string s;
        s = $sformatf("tx %0b/%02h start %0b/%02h rx %0b", r.tx_valid, r.tx_byte,
                      r.send_start, r.start_address, r.receive_mode);
        return {s, $sformatf(" stop %0b sas %0b fin %0b st %0d rb %02h", r.send_stop,
                             r.stop_after_start, r.finished, r.status, r.read_byte)};
    endfunction

    // Drive one item, record its expected result and hold until accepted
    task automatic send_item(input t_seq_item it);
        int          gap;
        bit          effective;
        t_seq_result exp_result;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode          <= it.mode;
        i_index         <= it.index;
        i_byte_value    <= it.byte_value;
        i_slave_address <= it.slave_address;
        i_addr_count    <= it.addr_count;
        i_data_count    <= it.data_count;
        i_is_read       <= it.is_read;
        i_in_valid      <= 1'b1;
        exp_result = sequence_step(it, effective);
        pending_results.push_back(exp_result);
        items_sent++;
        if (effective)
            items_effective++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Feed ready events until the current transfer ends
    task automatic finish_transfer();
        while (seq_events_on)
            send_item(seq_item(i2crts_pkg::MODE_READY, $urandom_range(0, 31),
                               $urandom_range(0, 255), 0, 0, 0, 1'b0));
    endtask

    // Begin a transfer with the given counts and direction
    task automatic start_transfer(input int ac, input int dc, input bit rd);
        send_item(seq_item(i2crts_pkg::MODE_START, $urandom_range(0, 31),
                           $urandom_range(0, 255), $urandom_range(0, 127), ac, dc, rd));
    endtask

    // Events and unused codes straight after reset must be ignored
    task automatic test_idle_events();
        send_item(rand_item(i2crts_pkg::MODE_READY));
        send_item(rand_item(i2crts_pkg::MODE_NACK));
        send_item(rand_item(MODE_SPARE_LO));
        send_item(rand_item(MODE_SPARE_HI));
        send_item(rand_item(i2crts_pkg::MODE_READY));
    endtask

    // Fill both buffers, try loads past the end, read the data back
    task automatic test_load_buffers();
        int k;
        for (k = 0; k < ADDR_DEPTH; k++)
            send_item(seq_item(i2crts_pkg::MODE_LOAD_ADDR, k, $urandom_range(0, 255),
                               0, 0, 0, 1'b0));
        for (k = 0; k < DATA_DEPTH; k++)
            send_item(seq_item(i2crts_pkg::MODE_LOAD_DATA, k, $urandom_range(0, 255),
                               0, 0, 0, 1'b0));
        for (k = 0; k < 4; k++)
            send_item(seq_item(i2crts_pkg::MODE_LOAD_ADDR,
                               $urandom_range(ADDR_DEPTH, 31), $urandom_range(0, 255),
                               0, 0, 0, 1'b0));
        for (k = 0; k < DATA_DEPTH; k++)
            send_item(seq_item(i2crts_pkg::MODE_READ_BACK, k, 0, 0, 0, 0, 1'b0));
    endtask

    // Write transfers of random lengths
    task automatic test_write_transfers();
        int n;
        for (n = 0; n < 20; n++) begin
            send_item(rand_item(i2crts_pkg::MODE_LOAD_DATA));
            send_item(rand_item(i2crts_pkg::MODE_LOAD_ADDR));
            start_transfer($urandom_range(0, ADDR_DEPTH), $urandom_range(0, DATA_DEPTH), 1'b0);
            finish_transfer();
        end
    endtask

    // Read transfers, then read back part of what came in
    task automatic test_read_transfers();
        int n;
        int k;
        for (n = 0; n < 15; n++) begin
            start_transfer($urandom_range(0, ADDR_DEPTH), $urandom_range(1, DATA_DEPTH), 1'b1);
            finish_transfer();
            for (k = 0; k < 3; k++)
                send_item(rand_item(i2crts_pkg::MODE_READ_BACK));
        end
    endtask

    // Empty transfers, saturated counts, one-byte reads, busy starts, aborts
    task automatic test_corner_cases();
        start_transfer(0, 0, 1'b0);
        finish_transfer();
        start_transfer(0, 0, 1'b1);
        finish_transfer();
        start_transfer(7, 63, 1'b0);
        finish_transfer();
        start_transfer(7, 63, 1'b1);
        finish_transfer();
        start_transfer(0, 1, 1'b1);
        finish_transfer();
        start_transfer(ADDR_DEPTH, 1, 1'b1);
        finish_transfer();
        start_transfer(2, 5, 1'b0);
        start_transfer(1, 3, 1'b1);
        send_item(rand_item(MODE_SPARE_LO));
        send_item(rand_item(i2crts_pkg::MODE_READY));
        send_item(rand_item(MODE_SPARE_HI));
        finish_transfer();
        start_transfer(3, 8, 1'b1);
        send_item(rand_item(i2crts_pkg::MODE_READY));
        send_item(rand_item(i2crts_pkg::MODE_NACK));
        send_item(rand_item(i2crts_pkg::MODE_NACK));
        send_item(rand_item(i2crts_pkg::MODE_READY));
        start_transfer(1, 4, 1'b0);
        send_item(rand_item(i2crts_pkg::MODE_NACK));
        start_transfer(0, 2, 1'b1);
        finish_transfer();
    endtask

    // Items with no gaps on the input side
    task automatic test_back_to_back();
        int n;
        tx_idle_on = 1'b0;
        for (n = 0; n < 6; n++) begin
            send_item(rand_item(i2crts_pkg::MODE_LOAD_DATA));
            start_transfer($urandom_range(0, ADDR_DEPTH), $urandom_range(0, 12),
                           1'($urandom_range(0, 1)));
            finish_transfer();
            send_item(rand_item(i2crts_pkg::MODE_READ_BACK));
        end
        tx_idle_on = 1'b1;
    endtask

    // Random mix of every mode until the item budget is spent
    task automatic test_random_mix();
        int          r;
        logic [2:0]  m;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                m = i2crts_pkg::MODE_LOAD_ADDR;
            else if (r < 25)
                m = i2crts_pkg::MODE_LOAD_DATA;
            else if (r < 35)
                m = i2crts_pkg::MODE_START;
            else if (r < 80)
                m = i2crts_pkg::MODE_READY;
            else if (r < 85)
                m = i2crts_pkg::MODE_NACK;
            else if (r < 95)
                m = i2crts_pkg::MODE_READ_BACK;
            else if (r < 97)
                m = MODE_SPARE_LO;
            else
                m = MODE_SPARE_HI;
            send_item(rand_item(m));
        end
    endtask

    initial begin
        int wait_cycles;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_events();
        test_load_buffers();
        test_write_transfers();
        test_read_transfers();
        test_corner_cases();
        test_back_to_back();
        test_random_mix();

        // Drain the outstanding results
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            failures++;
        end

        $display("Sent %0d items (%0d with effect), checked %0d results, %0d mismatches",
                 items_sent, items_effective, results_checked, failures);
        $display("Transfers: %0d writes and %0d reads completed, %0d aborted by nack",
                 writes_completed, reads_completed, transfers_aborted);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Check each result against the oldest expectation; stall the receiver
    always @(posedge i_clk) begin
        t_seq_result got;
        t_seq_result exp_result;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.tx_valid         = o_tx_valid;
            got.tx_byte          = o_tx_byte;
            got.send_start       = o_send_start;
            got.start_address    = o_start_address;
            got.receive_mode     = o_receive_mode;
            got.send_stop        = o_send_stop;
            got.stop_after_start = o_stop_after_start;
            got.finished         = o_finished;
            got.status           = o_status;
            got.read_byte        = o_read_byte;
            if (pending_results.size() == 0) begin
                if (failures < REPORT_MAX)
                    $display("%0t: unexpected result %s", $realtime, show_result(got));
                failures++;
            end else begin
                exp_result = pending_results.pop_front();
                results_checked++;
                if (got !== exp_result) begin
                    if (failures < REPORT_MAX) begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("  expected %s", show_result(exp_result));
                        $display("  actual   %s", show_result(got));
                    end
                    failures++;
                end
            end
        end
        if (rx_calm_left == 0) begin
            rx_calm_left = $urandom_range(20, 200);
            rx_idle_on = ($urandom_range(0, 4) != 0);
        end
        rx_calm_left--;
        if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0)
            rx_stall_left = pick_gap();
        if (rx_stall_left > 0) begin
            i_out_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

endmodule
